// ===== rtl/wrik_pkg.sv =====
// Shared types, widths and constants for the wheel RPM inverse kinematics unit.
package wrik_pkg;

  localparam int InW     = 16;
  localparam int OutW    = 20;
  localparam int FacW    = 18;
  localparam int MaxW    = 19;
  localparam int TermW   = 19;  // |term| < 2^18 after rounding
  localparam int MagW    = 18;
  localparam int SumW    = 20;  // sum of two magnitudes
  localparam int NumW    = MagW + MaxW + 1;  // 2*mag*m, fits 38 bits
  localparam int QW      = MaxW + 1;         // quotient < 2*m/2, bounded by m
  localparam int DivSteps = QW;
  localparam int ShW     = $clog2(DivSteps); // divisor shift for one step

  typedef enum logic [1:0] {
    CFG_BASE_KIND   = 2'd0,
    CFG_RPM_SPEED   = 2'd1,
    CFG_RPM_TURN    = 2'd2,
    CFG_MAX_RPM     = 2'd3
  } cfg_idx_t;

  localparam logic [1:0] KIND_DIFF    = 2'd0;
  localparam logic [1:0] KIND_SKID    = 2'd1;
  localparam logic [1:0] KIND_MECANUM = 2'd2;
  localparam logic [1:0] KIND_SPARE   = 2'd3;  // unused, acts as mecanum

  // Scaling selection carried down the pipe.
  typedef struct packed {
    logic scale_xy;
    logic scale_xt;
  } scale_sel_t;

  // One divider lane: restoring long division of a numerator by a divisor.
  typedef struct packed {
    logic [NumW-1:0] rem;
    logic [QW-1:0]   quo;
  } div_lane_t;

endpackage

// ===== rtl/wheel_rpm_inverse_kinematics_unit.sv =====
// Wheel RPM inverse kinematics unit: velocity command in, four wheel RPM targets out.
//
// Pipeline: stage 1 multiplies the three axes by their rpm factors; stage 2
// rounds, takes magnitudes, pair sums and picks which pair (if any) is scaled
// to max_rpm over the pair sum; a restoring divider then runs one quotient bit
// per stage (20 stages) on the x term and its paired term at once; the last stage mixes
// the three terms into four wheels and saturates to plus or minus max_rpm. One
// request enters per cycle while the output is not held. The whole pipe
// advances together and freezes when the output is held, so a stall drops or
// repeats nothing. Configuration is sampled as items pass, so write only while
// idle.
module wheel_rpm_inverse_kinematics_unit import wrik_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [1:0]             cfg_index,
  input  logic [MaxW-1:0]        cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic signed [InW-1:0]  speed_forward,
  input  logic signed [InW-1:0]  speed_sideways,
  input  logic signed [InW-1:0]  turn_rate,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic signed [OutW-1:0] front_left_rpm,
  output logic signed [OutW-1:0] front_right_rpm,
  output logic signed [OutW-1:0] rear_left_rpm,
  output logic signed [OutW-1:0] rear_right_rpm
);

  localparam int NSt = DivSteps + 3;
  localparam int L   = DivSteps + 1;

  // configuration registers
  logic [1:0]      base_kind;
  logic [FacW-1:0] rpm_per_speed, rpm_per_turn_rate;
  logic [MaxW-1:0] max_rpm;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_kind         <= KIND_DIFF;
      rpm_per_speed     <= FacW'(48893);
      rpm_per_turn_rate <= FacW'(4889);
      max_rpm           <= MaxW'(1600);
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_BASE_KIND: base_kind         <= cfg_data[1:0];
        CFG_RPM_SPEED: rpm_per_speed     <= cfg_data[FacW-1:0];
        CFG_RPM_TURN:  rpm_per_turn_rate <= cfg_data[FacW-1:0];
        CFG_MAX_RPM:   max_rpm           <= cfg_data;
        default: ;
      endcase
    end
  end

  // global advance: whole pipe moves unless the output is full and held
  logic [NSt-1:0] vld;
  logic adv;
  assign adv       = !vld[NSt-1] || out_ready;
  assign in_ready  = adv;
  assign out_valid = vld[NSt-1];

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (adv) vld <= {vld[NSt-2:0], in_valid};
  end

  // stage 1: products
  logic signed [InW+FacW:0] p_x, p_y, p_t;
  logic s1_wz0, s1_vy0;
  always_ff @(posedge clk) begin
    if (adv) begin
      logic signed [InW-1:0] vy;
      vy = (base_kind == KIND_DIFF || base_kind == KIND_SKID) ? '0 : speed_sideways;
      p_x    <= speed_forward * $signed({1'b0, rpm_per_speed});
      p_y    <= vy * $signed({1'b0, rpm_per_speed});
      p_t    <= turn_rate * $signed({1'b0, rpm_per_turn_rate});
      s1_wz0 <= turn_rate == '0;
      s1_vy0 <= vy == '0;
    end
  end

  // stage 2: round, magnitudes, pair choice, numerators
  logic signed [InW+FacW:0] r_x, r_y, r_t;
  logic signed [TermW-1:0]  x, y, t;
  logic [MagW-1:0]          ax, ay, at;
  logic [SumW-1:0]          sxy, sxt;
  always_comb begin
    r_x = p_x + (InW+FacW+1)'(32768);
    r_y = p_y + (InW+FacW+1)'(32768);
    r_t = p_t + (InW+FacW+1)'(32768);
    x = TermW'(r_x >>> 16);
    y = TermW'(r_y >>> 16);
    t = TermW'(r_t >>> 16);
    ax = MagW'(x < 0 ? -x : x);
    ay = MagW'(y < 0 ? -y : y);
    at = MagW'(t < 0 ? -t : t);
    sxy = SumW'(ax) + SumW'(ay);
    sxt = SumW'(ax) + SumW'(at);
  end

  scale_sel_t              sel    [1:L];
  logic signed [TermW-1:0] tx     [1:L], ty [1:L], tt [1:L];
  logic [SumW:0]           dvs    [1:DivSteps];
  logic [MaxW-1:0]         mx     [1:L];
  div_lane_t               lane   [DivSteps+1][3];

  always_ff @(posedge clk) begin
    if (adv) begin
      logic xy, xt;
      logic [SumW-1:0] s;
      xy = (sxy >= SumW'(max_rpm)) && s1_wz0 && (sxy != '0);
      xt = !((sxy >= SumW'(max_rpm)) && s1_wz0) && (sxt >= SumW'(max_rpm))
           && s1_vy0 && (sxt != '0);
      s  = xy ? sxy : sxt;
      sel[1] <= '{scale_xy: xy, scale_xt: xt};
      tx[1] <= x; ty[1] <= y; tt[1] <= t;
      mx[1] <= max_rpm;
      dvs[1] <= {s, 1'b0};
      lane[0][0].rem <= NumW'({ax, 1'b0}) * NumW'(max_rpm) + NumW'(s);
      lane[0][1].rem <= NumW'({(xy ? ay : at), 1'b0}) * NumW'(max_rpm) + NumW'(s);
      lane[0][2].rem <= '0;
      for (int i = 0; i < 3; i++) lane[0][i].quo <= '0;
    end
  end

  // divider stages; side data moves alongside
  for (genvar k = 0; k < DivSteps; k++) begin : g_div
    wrik_div_stage u_st (
      .clk     (clk),
      .en      (adv),
      .sh      (ShW'(DivSteps - 1 - k)),
      .dvs     (dvs[k+1]),
      .lane_in (lane[k]),
      .lane_out(lane[k+1])
    );
    always_ff @(posedge clk) begin
      if (adv) begin
        sel[k+2] <= sel[k+1]; tx[k+2] <= tx[k+1]; ty[k+2] <= ty[k+1];
        tt[k+2] <= tt[k+1]; mx[k+2] <= mx[k+1];
      end
    end
    if (k > 0) begin : g_dvs
      always_ff @(posedge clk) begin
        if (adv) dvs[k+1] <= dvs[k];
      end
    end
  end

  // final stage: apply scaled terms, mix and saturate
  always_ff @(posedge clk) begin
    if (adv) begin
      logic signed [TermW+1:0] fx, fy, ft, m;
      logic signed [TermW+1:0] w [4];
      logic signed [TermW+1:0] q0, q1;
      q0 = $signed({1'b0, lane[DivSteps][0].quo});
      q1 = $signed({1'b0, lane[DivSteps][1].quo});
      fx = (TermW+2)'(tx[L]); fy = (TermW+2)'(ty[L]); ft = (TermW+2)'(tt[L]);
      if (sel[L].scale_xy || sel[L].scale_xt) fx = tx[L] < 0 ? -q0 : q0;
      if (sel[L].scale_xy) fy = ty[L] < 0 ? -q1 : q1;
      if (sel[L].scale_xt) ft = tt[L] < 0 ? -q1 : q1;
      m = $signed({2'b0, mx[L]});
      w[0] = fx - fy - ft;
      w[1] = fx + fy + ft;
      w[2] = fx + fy - ft;
      w[3] = fx - fy + ft;
      for (int i = 0; i < 4; i++) begin
        if (w[i] > m) w[i] = m;
        if (w[i] < -m) w[i] = -m;
      end
      front_left_rpm  <= OutW'(w[0]);
      front_right_rpm <= OutW'(w[1]);
      rear_left_rpm   <= OutW'(w[2]);
      rear_right_rpm  <= OutW'(w[3]);
    end
  end

  logic unused;
  assign unused = ^{lane[DivSteps][0].rem, lane[DivSteps][1].rem, lane[DivSteps][2]};

endmodule

// ===== rtl/wrik_div_stage.sv =====
// One step of the pipelined restoring divider for the three divider lanes.
module wrik_div_stage import wrik_pkg::*; (
  input  logic            clk,
  input  logic            en,
  input  logic [ShW-1:0]  sh,
  input  logic [SumW:0]   dvs,
  input  div_lane_t       lane_in  [3],
  output div_lane_t       lane_out [3]
);

  for (genvar g = 0; g < 3; g++) begin : g_lane
    logic fit;
    always_comb begin
      fit = ({{QW{1'b0}}, lane_in[g].rem} >> sh) >= {{(NumW+QW-SumW-1){1'b0}}, dvs};
    end
    always_ff @(posedge clk) begin
      if (en) begin
        lane_out[g].rem <= fit ? (lane_in[g].rem - NumW'({{(NumW-SumW-1){1'b0}}, dvs} << sh))
                               : lane_in[g].rem;
        lane_out[g].quo <= {lane_in[g].quo[QW-2:0], fit};
      end
    end
  end

endmodule
